### src/sfxd_pkg.sv
// shared types and constants for the sync/xor frame deframer
// no dependencies; imported by sync_frame_xor_deframer
package sfxd_pkg;

  // frame buffer size, a frame is dropped when its byte count reaches it
  localparam int unsigned BUFFER_BYTES = 28;
  localparam int unsigned CNT_W        = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned LEN_W        = 5;

  localparam logic [7:0] SYNC_RESET = 8'h5a;
  localparam logic [7:0] TAIL_RESET = 8'ha5;

  // apb address and register map
  localparam int unsigned ADDR_W = 3;
  localparam logic        REG_SYNC = 1'b0;
  localparam logic        REG_TAIL = 1'b1;

  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_GOOD     = 3'd1,
    ST_BAD      = 3'd2,
    ST_HEADER   = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  typedef struct packed {
    status_e          status;
    logic [LEN_W-1:0] frame_length;
  } result_t;

endpackage

### src/sync_frame_xor_deframer.sv
// sync/xor frame deframer: byte-wise frame checker with a two-word result queue
// depends on sfxd_pkg
// each accepted byte's result word is written into the result queue register before it reaches the output
// throughput: one byte per cycle while rx_stall_o is low; all frame checks are a compare, a count and an xor
// a two-word result queue lets bytes keep flowing while one result waits
// reset: frame state and queue cleared, sync byte 0x5a, tail byte 0xa5
module sync_frame_xor_deframer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // received bytes
  input  logic                       rx_valid_i,
  output logic                       rx_stall_o,
  input  logic [7:0]                 rx_byte_i,
  // per-byte result words
  output logic                       res_valid_o,
  input  logic                       res_stall_i,
  output logic [2:0]                 status_o,
  output logic [sfxd_pkg::LEN_W-1:0] frame_length_o,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfxd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import sfxd_pkg::*;

  // configuration registers
  logic [7:0] sync_q;
  logic [7:0] tail_q;
  logic       cfg_wr;

  // frame state
  logic [CNT_W-1:0] byte_cnt_q, byte_cnt_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       xor_q, xor_d;
  logic [7:0]       rb0_q, rb1_q, rb2_q;
  logic [7:0]       rb0_d, rb1_d, rb2_d;

  // result queue
  result_t    fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       push, pop;

  logic [CNT_W-1:0] n;
  logic             clear;
  logic             frame_ok;
  result_t          res_d;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_TAIL) ? 32'(tail_q) : 32'(sync_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SYNC_RESET;
      tail_q <= TAIL_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_TAIL) begin
        tail_q <= pwdata[7:0];
      end else begin
        sync_q <= pwdata[7:0];
      end
    end
  end

  assign rx_stall_o  = (fill_q == 2'd2);
  assign res_valid_o = (fill_q != 2'd0);
  assign push        = rx_valid_i && !rx_stall_o;
  assign pop         = res_valid_o && !res_stall_i;

  // per-byte frame step
  always_comb begin
    n        = byte_cnt_q + CNT_W'(1);
    xor_d    = (byte_cnt_q >= CNT_W'(3)) ? (xor_q ^ rb0_q) : xor_q;
    len_d    = (byte_cnt_q == CNT_W'(2)) ? rx_byte_i : len_q;
    rb0_d    = rb1_q;
    rb1_d    = rb2_q;
    rb2_d    = rx_byte_i;
    frame_ok = (rb0_d == xor_d) && (rb1_d == tail_q) && (rb2_d == tail_q);

    res_d.status       = ST_BUSY;
    res_d.frame_length = LEN_W'(n);
    if (n == CNT_W'(3) && (rb0_d != sync_q || rb1_d != sync_q)) begin
      res_d.status = ST_HEADER;
    end else if (32'(n) >= 32'(BUFFER_BYTES)) begin
      res_d.status = ST_OVERFLOW;
    end else if (n > CNT_W'(4) && 32'(n) == 32'(len_d)) begin
      res_d.status = frame_ok ? ST_GOOD : ST_BAD;
    end

    clear      = (res_d.status != ST_BUSY);
    byte_cnt_d = n;
    if (clear) begin
      byte_cnt_d = '0;
      len_d      = '0;
      xor_d      = '0;
      rb0_d      = '0;
      rb1_d      = '0;
      rb2_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= '0;
      len_q      <= '0;
      xor_q      <= '0;
      rb0_q      <= '0;
      rb1_q      <= '0;
      rb2_q      <= '0;
    end else if (push) begin
      byte_cnt_q <= byte_cnt_d;
      len_q      <= len_d;
      xor_q      <= xor_d;
      rb0_q      <= rb0_d;
      rb1_q      <= rb1_d;
      rb2_q      <= rb2_d;
    end
  end

  // result queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res_d;
    end
  end

  assign status_o       = fifo_q[rd_ptr_q].status;
  assign frame_length_o = fifo_q[rd_ptr_q].frame_length;

  // checks
  a_fill_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= 2'd2)
    else $error("result queue overfilled");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(byte_cnt_q) < 32'(BUFFER_BYTES))
    else $error("byte count reached buffer size");

  a_clear_after_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && (res_d.status != ST_BUSY) |=> (byte_cnt_q == '0) && (xor_q == 8'd0))
    else $error("frame state not cleared after frame end");

  a_push_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> fill_q == $past(fill_q) + 2'd1)
    else $error("queue fill level did not follow push");

endmodule
